// ===== rtl/cbse_pkg.sv =====
// Shared widths, constants and helpers for the command-based scale estimator.
package cbse_pkg;

  localparam int unsigned VelW = 16;
  localparam int unsigned PosW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ThrW = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned OutW = 32;
  localparam int unsigned SumW = 64;
  localparam int unsigned RadW = 68;
  localparam int unsigned RootW = 34;
  localparam int unsigned ProdW = 70;
  localparam int unsigned MulBW = 35;
  localparam int unsigned DenW = 64;

  localparam int unsigned RefRefreshPeriod = 10;
  localparam logic [ThrW-1:0] ThrReset = 16'd20;

  // 2^15 * 10^6: Q1.15 one times microseconds per second.
  localparam logic [MulBW-1:0] ScaleK = 35'd32768000000;

  localparam logic [CfgIdxW-1:0] CfgHitThr = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSampleThr = 8'd1;

  function automatic logic [VelW:0] abs16(input logic [VelW-1:0] v);
    logic [VelW:0] e;
    e = {v[VelW-1], v};
    return e[VelW] ? (~e + 1'b1) : e;
  endfunction

  function automatic logic [PosW:0] absdiff32(input logic [PosW-1:0] a,
                                              input logic [PosW-1:0] b);
    logic [PosW:0] d;
    d = {a[PosW-1], a} - {b[PosW-1], b};
    return d[PosW] ? (~d + 1'b1) : d;
  endfunction

endpackage

// ===== rtl/cbse_sqrt.sv =====
// Digit-by-digit floor square root, two radicand bits per cycle.
module cbse_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cbse_pkg::RadW-1:0] rad_i,
  output logic                      done_o,
  output logic [cbse_pkg::RootW-1:0] root_o
);
  import cbse_pkg::*;

  localparam int unsigned RemW = RootW + 2;
  localparam int unsigned CntW = $clog2(RootW);

  logic [RadW-1:0] rad_q;
  logic [RemW-1:0] rem_q;
  logic [RootW-1:0] root_q;
  logic [CntW-1:0] cnt_q;
  logic busy_q, done_q;
  logic [RemW+1:0] cand, trial, diff;
  logic ge;

  assign cand  = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = cand >= trial;
  assign diff  = cand - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(RootW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(RootW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= ge ? diff[RemW-1:0] : cand[RemW-1:0];
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/cbse_div.sv =====
// Restoring divider, one numerator bit per cycle, saturating 32-bit quotient.
module cbse_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cbse_pkg::ProdW-1:0] num_i,
  input  logic [cbse_pkg::DenW-1:0]  den_i,
  output logic                       done_o,
  output logic [cbse_pkg::OutW-1:0]  quo_o
);
  import cbse_pkg::*;

  localparam int unsigned CntW = $clog2(ProdW);
  localparam int unsigned LastHi = ProdW - OutW - 1;

  logic [ProdW-1:0] num_q;
  logic [DenW-1:0] den_q, rem_q;
  logic [OutW-1:0] quo_q;
  logic over_q, busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0] cand, diff;
  logic ge;

  assign cand = {rem_q, num_q[ProdW-1]};
  assign ge   = cand >= {1'b0, den_q};
  assign diff = cand - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(ProdW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(ProdW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quo_q  <= '0;
      over_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[ProdW-2:0], 1'b0};
      rem_q <= ge ? diff[DenW-1:0] : cand[DenW-1:0];
      quo_q <= {quo_q[OutW-2:0], ge};
      if (ge && cnt_q <= CntW'(LastHi)) begin
        over_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = over_q ? '1 : quo_q;

endmodule

// ===== rtl/command_based_scale_estimator.sv =====
// Top level: command matching, pose reference tracking and scale estimation.
// Command words and a first pose are handled in S_IDLE; a pose whose hit count is
// not above the hit threshold goes to S_FIN, then S_MDIV and S_OUT when a mean is
// reported. An estimating pose runs eight 35-step shift-add squarings and products,
// two 34-step roots, up to two 70-step divisions (fewer for zero time or speed).
// One word is in work at a time; a held result stalls the report. Async reset, low.
module command_based_scale_estimator #(
  parameter int unsigned REF_REFRESH_PERIOD = cbse_pkg::RefRefreshPeriod
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [cbse_pkg::VelW-1:0]     vel_x_i,
  input  logic [cbse_pkg::VelW-1:0]     vel_y_i,
  input  logic [cbse_pkg::VelW-1:0]     vel_z_i,
  input  logic [cbse_pkg::PosW-1:0]     pos_x_i,
  input  logic [cbse_pkg::PosW-1:0]     pos_y_i,
  input  logic [cbse_pkg::PosW-1:0]     pos_z_i,
  input  logic [cbse_pkg::TimeW-1:0]    time_stamp_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cbse_pkg::OutW-1:0]     scale_mean_o,
  output logic [cbse_pkg::OutW-1:0]     latest_estimate_o,
  output logic                          estimate_fresh_o,
  output logic [cbse_pkg::OutW-1:0]     sample_count_o,
  input  logic                          cfg_we_i,
  input  logic [cbse_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbse_pkg::ThrW-1:0]     cfg_data_i
);
  import cbse_pkg::*;

  localparam int unsigned PhaseW = (REF_REFRESH_PERIOD > 1) ? $clog2(REF_REFRESH_PERIOD) : 1;
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(REF_REFRESH_PERIOD - 1);
  localparam logic [PhaseW-1:0] PhaseFirst = PhaseW'(1 % REF_REFRESH_PERIOD);
  localparam int unsigned MulCntW = $clog2(MulBW);

  typedef enum logic [3:0] {
    S_IDLE, S_VSQ, S_VRT, S_DEN, S_DSQ, S_DRT, S_NUM, S_EDIV, S_FIN, S_MDIV, S_OUT
  } state_e;

  state_e state_q;

  logic [ThrW-1:0] hit_thr_q, sample_thr_q, hit_count_q;
  logic [VelW-1:0] tvx_q, tvy_q, tvz_q;
  logic pose_seen_q;
  logic [PhaseW-1:0] phase_q;
  logic [PosW-1:0] ref_x_q, ref_y_q, ref_z_q, px_q, py_q, pz_q;
  logic [TimeW-1:0] ref_t_q, ts_q;
  logic [SumW-1:0] sum_q;
  logic [OutW-1:0] total_q, est_q, mean_q;
  logic fresh_q;
  logic [DenW-1:0] den_q;
  logic [1:0] comp_q;

  logic [ProdW-1:0] mul_a_q, acc_q;
  logic [MulBW-1:0] mul_b_q;
  logic [MulCntW-1:0] mul_cnt_q;
  logic mul_busy_q;

  logic sqrt_start_q, div_start_q;
  logic [RadW-1:0] rad_q;
  logic [ProdW-1:0] num_q;
  logic [DenW-1:0] dden_q;
  logic sqrt_done, div_done;
  logic [RootW-1:0] root;
  logic [OutW-1:0] quo;

  logic out_valid_q, out_fresh_q;
  logic [OutW-1:0] out_mean_q, out_est_q, out_cnt_q;

  logic accept, vel_match, vel_pos;
  logic [VelW+1:0] vel_sum;
  logic [VelW:0] vnext;
  logic [PosW:0] dnext;
  logic [TimeW-1:0] dt;
  logic [SumW:0] sum_ext;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign vel_match = (vel_x_i == tvx_q) && (vel_y_i == tvy_q) && (vel_z_i == tvz_q);
  assign vel_sum   = {{2{vel_x_i[VelW-1]}}, vel_x_i} + {{2{vel_y_i[VelW-1]}}, vel_y_i}
                   + {{2{vel_z_i[VelW-1]}}, vel_z_i};
  assign vel_pos   = !vel_sum[VelW+1] && (vel_sum != '0);
  assign vnext     = (comp_q == 2'd0) ? abs16(tvy_q) : abs16(tvz_q);
  assign dnext     = (comp_q == 2'd0) ? absdiff32(py_q, ref_y_q) : absdiff32(pz_q, ref_z_q);
  assign dt        = ts_q - ref_t_q;
  assign sum_ext   = {1'b0, sum_q} + {{(SumW-OutW+1){1'b0}}, (quo)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      hit_thr_q    <= ThrReset;
      sample_thr_q <= ThrReset;
      hit_count_q  <= '0;
      tvx_q        <= '0;
      tvy_q        <= '0;
      tvz_q        <= '0;
      pose_seen_q  <= 1'b0;
      phase_q      <= '0;
      ref_x_q      <= '0;
      ref_y_q      <= '0;
      ref_z_q      <= '0;
      ref_t_q      <= '0;
      sum_q        <= '0;
      total_q      <= '0;
      mul_busy_q   <= 1'b0;
      sqrt_start_q <= 1'b0;
      div_start_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      sqrt_start_q <= !mul_busy_q && (comp_q == 2'd2)
                      && (state_q == S_VSQ || state_q == S_DSQ);
      div_start_q  <= (state_q == S_NUM && !mul_busy_q)
                      || (state_q == S_FIN && total_q > OutW'(sample_thr_q));

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgHitThr:    hit_thr_q <= cfg_data_i;
          CfgSampleThr: sample_thr_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (mul_busy_q) begin
        acc_q     <= acc_q + (mul_b_q[0] ? mul_a_q : '0);
        mul_a_q   <= {mul_a_q[ProdW-2:0], 1'b0};
        mul_b_q   <= {1'b0, mul_b_q[MulBW-1:1]};
        mul_cnt_q <= mul_cnt_q + 1'b1;
        if (mul_cnt_q == MulCntW'(MulBW - 1)) begin
          mul_busy_q <= 1'b0;
        end
      end

      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (!cmd_i) begin
              if (vel_match) begin
                if (hit_count_q != '1) begin
                  hit_count_q <= hit_count_q + 1'b1;
                end
              end else begin
                hit_count_q <= '0;
                if (vel_pos) begin
                  tvx_q <= vel_x_i;
                  tvy_q <= vel_y_i;
                  tvz_q <= vel_z_i;
                end
              end
            end else begin
              px_q <= pos_x_i;
              py_q <= pos_y_i;
              pz_q <= pos_z_i;
              ts_q <= time_stamp_i;
              fresh_q <= 1'b0;
              est_q <= '0;
              if (!pose_seen_q) begin
                ref_x_q     <= pos_x_i;
                ref_y_q     <= pos_y_i;
                ref_z_q     <= pos_z_i;
                ref_t_q     <= time_stamp_i;
                pose_seen_q <= 1'b1;
                phase_q     <= PhaseFirst;
              end else if (hit_count_q > hit_thr_q) begin
                mul_a_q    <= ProdW'(abs16(tvx_q));
                mul_b_q    <= MulBW'(abs16(tvx_q));
                acc_q      <= '0;
                mul_cnt_q  <= '0;
                mul_busy_q <= 1'b1;
                comp_q     <= 2'd0;
                state_q    <= S_VSQ;
              end else begin
                state_q <= S_FIN;
              end
            end
          end
        end
        S_VSQ: begin
          if (!mul_busy_q) begin
            if (comp_q == 2'd2) begin
              rad_q   <= acc_q[RadW-1:0];
              state_q <= S_VRT;
            end else begin
              mul_a_q    <= ProdW'(vnext);
              mul_b_q    <= MulBW'(vnext);
              mul_cnt_q  <= '0;
              mul_busy_q <= 1'b1;
              comp_q     <= comp_q + 1'b1;
            end
          end
        end
        S_VRT: begin
          if (sqrt_done) begin
            if (dt == '0 || root == '0) begin
              state_q <= S_FIN;
            end else begin
              mul_a_q    <= ProdW'(dt);
              mul_b_q    <= MulBW'(root);
              acc_q      <= '0;
              mul_cnt_q  <= '0;
              mul_busy_q <= 1'b1;
              state_q    <= S_DEN;
            end
          end
        end
        S_DEN: begin
          if (!mul_busy_q) begin
            den_q      <= acc_q[DenW-1:0];
            mul_a_q    <= ProdW'(absdiff32(px_q, ref_x_q));
            mul_b_q    <= MulBW'(absdiff32(px_q, ref_x_q));
            acc_q      <= '0;
            mul_cnt_q  <= '0;
            mul_busy_q <= 1'b1;
            comp_q     <= 2'd0;
            state_q    <= S_DSQ;
          end
        end
        S_DSQ: begin
          if (!mul_busy_q) begin
            if (comp_q == 2'd2) begin
              rad_q   <= acc_q[RadW-1:0];
              state_q <= S_DRT;
            end else begin
              mul_a_q    <= ProdW'(dnext);
              mul_b_q    <= MulBW'(dnext);
              mul_cnt_q  <= '0;
              mul_busy_q <= 1'b1;
              comp_q     <= comp_q + 1'b1;
            end
          end
        end
        S_DRT: begin
          if (sqrt_done) begin
            mul_a_q    <= ProdW'(root);
            mul_b_q    <= ScaleK;
            acc_q      <= '0;
            mul_cnt_q  <= '0;
            mul_busy_q <= 1'b1;
            state_q    <= S_NUM;
          end
        end
        S_NUM: begin
          if (!mul_busy_q) begin
            num_q   <= acc_q;
            dden_q  <= den_q;
            state_q <= S_EDIV;
          end
        end
        S_EDIV: begin
          if (div_done) begin
            est_q   <= quo;
            fresh_q <= 1'b1;
            sum_q   <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
            if (total_q != '1) begin
              total_q <= total_q + 1'b1;
            end
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (phase_q == '0) begin
            ref_x_q <= px_q;
            ref_y_q <= py_q;
            ref_z_q <= pz_q;
            ref_t_q <= ts_q;
          end
          phase_q <= (phase_q == PhaseLast) ? '0 : phase_q + 1'b1;
          if (total_q > OutW'(sample_thr_q)) begin
            num_q   <= ProdW'(sum_q);
            dden_q  <= DenW'(total_q);
            state_q <= S_MDIV;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            mean_q  <= quo;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_mean_q  <= mean_q;
            out_est_q   <= est_q;
            out_fresh_q <= fresh_q;
            out_cnt_q   <= total_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  cbse_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start_q),
    .rad_i   (rad_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  cbse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (num_q),
    .den_i   (dden_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign scale_mean_o      = out_mean_q;
  assign latest_estimate_o = out_est_q;
  assign estimate_fresh_o  = out_fresh_q;
  assign sample_count_o    = out_cnt_q;

endmodule

// ===== rtl/cbse_checker.sv =====
// Port-level checks for the scale estimator, bound to the top level.
module cbse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        cmd_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] latest_estimate_o,
  input logic        estimate_fresh_o,
  input logic [31:0] sample_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_count_o))
    else $error("result word dropped or changed while stalled");

  a_stale_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !estimate_fresh_o |-> latest_estimate_o == 32'd0)
    else $error("stale result carries an estimate");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o != 32'd0)
    else $error("result reported with no samples");

  a_cmd_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !cmd_i |=> !in_stall_o)
    else $error("command word held the input");

endmodule

bind command_based_scale_estimator cbse_checker u_cbse_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .cmd_i             (cmd_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .latest_estimate_o (latest_estimate_o),
  .estimate_fresh_o  (estimate_fresh_o),
  .sample_count_o    (sample_count_o)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for the command-based scale estimator.
`timescale 1ns / 1ps

typedef struct {
  logic [31:0] mean;
  logic [31:0] estimate;
  logic        fresh;
  logic [31:0] count;
} scale_report_t;

class scale_scoreboard;
  logic [15:0]   hit_thr, sample_thr;
  logic [15:0]   test_vx, test_vy, test_vz, hits;
  bit            seen;
  int unsigned   phase;
  logic [31:0]   ref_x, ref_y, ref_z, ref_t;
  logic [63:0]   est_sum;
  logic [31:0]   est_total;
  scale_report_t reports[$];
  int            errors;

  function new();
    hit_thr = cbse_pkg::ThrReset;
    sample_thr = cbse_pkg::ThrReset;
    test_vx = '0; test_vy = '0; test_vz = '0; hits = '0;
    seen = 0; phase = 0;
    ref_x = '0; ref_y = '0; ref_z = '0; ref_t = '0;
    est_sum = '0; est_total = '0;
    errors = 0;
  endfunction

  function void set_reg(logic [7:0] idx, logic [15:0] data);
    if (idx == cbse_pkg::CfgHitThr) hit_thr = data;
    else if (idx == cbse_pkg::CfgSampleThr) sample_thr = data;
  endfunction

  function logic [63:0] floor_root(logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r[63:0];
  endfunction

  function logic [127:0] sq_dist(logic [31:0] a, logic [31:0] b);
    longint d;
    logic [127:0] u;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d < 0) d = -d;
    u = 128'(d);
    return u * u;
  endfunction

  function void note_word(logic c, logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                          logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                          logic [31:0] ts);
    int            vsum;
    longint        a, b, d;
    logic [31:0]   dt, est;
    logic [63:0]   speed, span;
    logic [127:0]  num, den, q;
    logic [64:0]   acc;
    bit            fresh;
    scale_report_t rep;
    est = '0;
    fresh = 0;
    if (!c) begin
      vsum = int'($signed(vx)) + int'($signed(vy)) + int'($signed(vz));
      if (vx == test_vx && vy == test_vy && vz == test_vz) begin
        if (hits != 16'hFFFF) hits++;
      end else if (vsum > 0) begin
        test_vx = vx; test_vy = vy; test_vz = vz;
        hits = '0;
      end else begin
        hits = '0;
      end
      return;
    end
    if (!seen) begin
      ref_x = px; ref_y = py; ref_z = pz; ref_t = ts;
      seen = 1;
      phase = 1 % cbse_pkg::RefRefreshPeriod;
      return;
    end
    if (hits > hit_thr) begin
      dt = ts - ref_t;
      a = longint'($signed(test_vx));
      b = longint'($signed(test_vy));
      d = longint'($signed(test_vz));
      speed = floor_root(128'(a * a + b * b + d * d));
      if (dt != 0 && speed != 0) begin
        span = floor_root(sq_dist(px, ref_x) + sq_dist(py, ref_y) + sq_dist(pz, ref_z));
        num = 128'(span) * 128'(cbse_pkg::ScaleK);
        den = 128'(dt) * 128'(speed);
        q = num / den;
        est = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        fresh = 1;
        acc = {1'b0, est_sum} + 65'(est);
        est_sum = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
        if (est_total != 32'hFFFF_FFFF) est_total++;
      end
    end
    if (phase == 0) begin
      ref_x = px; ref_y = py; ref_z = pz; ref_t = ts;
    end
    phase = (phase + 1) % cbse_pkg::RefRefreshPeriod;
    if (est_total > 32'(sample_thr)) begin
      q = 128'(est_sum / 64'(est_total));
      rep.mean = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      rep.estimate = fresh ? est : 32'd0;
      rep.fresh = fresh;
      rep.count = est_total;
      reports.insert(reports.size(), rep);
    end
  endfunction

  function void check_result(logic [31:0] mean, logic [31:0] estimate, logic fresh,
                             logic [31:0] count);
    scale_report_t e;
    if (reports.size() == 0) begin
      $display("%0t: unexpected result mean=%h est=%h fresh=%b count=%h",
               $time, mean, estimate, fresh, count);
      errors++;
      return;
    end
    e = reports.pop_front();
    if (mean !== e.mean) begin
      $display("%0t: scale_mean expected %h actual %h", $time, e.mean, mean);
      errors++;
    end
    if (estimate !== e.estimate) begin
      $display("%0t: latest_estimate expected %h actual %h", $time, e.estimate, estimate);
      errors++;
    end
    if (fresh !== e.fresh) begin
      $display("%0t: estimate_fresh expected %b actual %b", $time, e.fresh, fresh);
      errors++;
    end
    if (count !== e.count) begin
      $display("%0t: sample_count expected %h actual %h", $time, e.count, count);
      errors++;
    end
  endfunction
endclass

module testbench;
  import cbse_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 8'd7;
  localparam int StallLimit = 8000;
  localparam int HoldCycles = 2000;
  localparam int SettleCycles = 450;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              cmd_i = 1'b0;
  logic [VelW-1:0]   vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [PosW-1:0]   pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [TimeW-1:0]  time_stamp_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [OutW-1:0]   scale_mean_o, latest_estimate_o, sample_count_o;
  logic              estimate_fresh_o;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ThrW-1:0]   cfg_data_i = '0;

  scale_scoreboard   sb = new();
  int                send_idle = 0, recv_idle = 0;
  bit                hold_req = 0;
  int                quiet = 0;
  logic [31:0]       cur_t = 32'd0;
  logic [31:0]       cur_x = 32'd0, cur_y = 32'd0, cur_z = 32'd0;

  always #1 clk_i = ~clk_i;

  command_based_scale_estimator DUT (.*);

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      sb.check_result(scale_mean_o, latest_estimate_o, estimate_fresh_o, sample_count_o);
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_idle);
      end
    end
  end

  task automatic send_word(logic c, logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [31:0] ts);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = c;
    vel_x_i = vx; vel_y_i = vy; vel_z_i = vz;
    pos_x_i = px; pos_y_i = py; pos_z_i = pz;
    time_stamp_i = ts;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(c, vx, vy, vz, px, py, pz, ts);
  endtask

  task automatic send_cmd(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
    send_word(1'b0, vx, vy, vz, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [31:0] ts);
    send_word(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), px, py, pz, ts);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ThrW-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_thresholds(logic [15:0] hit, logic [15:0] samp);
    write_reg(CfgHitThr, hit);
    write_reg(CfgSampleThr, samp);
  endtask

  task automatic step_pose();
    logic [31:0] step;
    step = ($urandom_range(19) == 0) ? 32'd0 : 32'($urandom_range(100000, 1));
    cur_t = cur_t + step;
    cur_x = cur_x + 32'($signed(20'($urandom)));
    cur_y = cur_y + 32'($signed(20'($urandom)));
    cur_z = cur_z + 32'($signed(20'($urandom)));
    send_pose(cur_x, cur_y, cur_z, cur_t);
  endtask

  task automatic run_random(int n);
    int          sent, k, m;
    logic [15:0] vx, vy, vz;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 75) begin
        do begin
          vx = 16'($urandom); vy = 16'($urandom); vz = 16'($urandom);
        end while (int'($signed(vx)) + int'($signed(vy)) + int'($signed(vz)) <= 0);
        k = (sb.hit_thr > 100) ? $urandom_range(5, 1)
            : $urandom_range(int'(sb.hit_thr) + 4, int'(sb.hit_thr) + 1);
        repeat (k) send_cmd(vx, vy, vz);
        m = $urandom_range(12, 2);
        repeat (m) step_pose();
        sent += k + m;
      end else begin
        if ($urandom_range(1)) send_cmd(16'($urandom), 16'($urandom), 16'($urandom));
        else send_pose($urandom, $urandom, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    send_idle = 30;
    recv_idle = 58;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_thresholds(16'd0, 16'd0);
    send_cmd(16'h0000, 16'h0000, 16'h0000);
    send_pose(32'd0, 32'd0, 32'd0, 32'd1000);
    send_pose(32'h0001_0000, 32'd0, 32'd0, 32'd2000);
    send_cmd(16'h7FFF, 16'h7FFF, 16'h8000);
    send_cmd(16'h7FFF, 16'h7FFF, 16'h8000);
    send_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3000);
    send_pose(32'h0000_1000, 32'hFFFF_0000, 32'd0, 32'd1000);
    send_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd500);
    send_cmd(16'h0001, 16'h0000, 16'h0000);
    send_cmd(16'h0001, 16'h0000, 16'h0000);
    send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1001);
    send_cmd(16'h8000, 16'h8000, 16'h8000);
    send_pose(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_cmd(16'h4000, 16'h0000, 16'h0000);
    send_cmd(16'h4000, 16'h0000, 16'h0000);
    repeat (8) step_pose();
    drain();

    set_thresholds(16'd3, 16'd5);
    run_random(150);
    drain();

    send_idle = 58;
    recv_idle = 30;
    set_thresholds(16'd0, 16'd65534);
    write_reg(CfgUnusedIdx, 16'hFFFF);
    run_random(100);
    drain();

    set_thresholds(16'd1, 16'd0);
    hold_req = 1;
    run_random(150);
    drain();

    send_idle = 0;
    recv_idle = 0;
    set_thresholds(16'd65534, 16'd2);
    repeat (20) send_cmd(16'h0100, 16'h0200, 16'h0000);
    repeat (12) step_pose();
    send_cmd(16'h0100, 16'h0200, 16'h0000);
    repeat (4) step_pose();
    drain();

    set_thresholds(16'd20, 16'd20);
    run_random(350);
    drain();

    if (sb.errors == 0 && sb.reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/cbse_pkg.sv
rtl/cbse_sqrt.sv
rtl/cbse_div.sv
rtl/command_based_scale_estimator.sv
rtl/cbse_checker.sv
bench/testbench.sv
